FILE: rtl/core/rhc_pkg.sv
package rhc_pkg;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      sector_type sector;
      logic       neg;
      logic       gray;
   } side_type;

endpackage

FILE: rtl/core/rgb_to_hsv_converter_core.sv
// channel  dir  tdata fields (low bit up)           handshake
// req      in   red, green, blue                    req_tvalid / req_tready
// rsp      out  hue, saturation, brightness         rsp_tvalid / rsp_tready
//
// One item per cycle while rsp_tready is not holding the pipe. Stages in order:
// classify stage, one restoring divide step per stage for both divisions,
// and the output register. STEPS = max(CHANNEL_BITS, HUE_FRAC_BITS + 1).
// Reset clears the stage valid bits only.
// Each stage holds while full and blocked; empty stages keep filling.
module rgb_to_hsv_converter_core import rhc_pkg::*; #(
   parameter int CHANNEL_BITS  = 8,
   parameter int HUE_FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // red, green, blue, zero pad
   input  logic [(3*CHANNEL_BITS+7)/8*8-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // hue, saturation, brightness, zero pad
   output logic [(HUE_FRAC_BITS+3+2*CHANNEL_BITS+7)/8*8-1:0] rsp_tdata
);

   localparam int CB    = CHANNEL_BITS;
   localparam int HFB   = HUE_FRAC_BITS;
   localparam int HW    = HFB + 3;
   localparam int STEPS = (CB > HFB + 1) ? CB : HFB + 1;
   localparam int RSP_W = ((HW + 2 * CB + 7) / 8) * 8;

   logic          p_valid   [0:STEPS];
   logic          p_ready   [0:STEPS];
   side_type      p_side    [0:STEPS];
   logic [CB-1:0] p_val     [0:STEPS];
   logic [CB-1:0] p_chroma  [0:STEPS];
   logic [CB-1:0] p_sat_rem [0:STEPS];
   logic [STEPS-1:0] p_sat_nq [0:STEPS];
   logic [CB-1:0] p_hue_rem [0:STEPS];
   logic [STEPS-1:0] p_hue_nq [0:STEPS];

   logic [HW-1:0] hue;
   logic [CB-1:0] saturation, brightness;

   rhc_front #(.CB(CB), .HFB(HFB), .S(STEPS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .red         (req_tdata[CB-1:0]),
      .green       (req_tdata[2*CB-1:CB]),
      .blue        (req_tdata[3*CB-1:2*CB]),
      .out_valid   (p_valid[0]),
      .out_ready   (p_ready[0]),
      .out_side    (p_side[0]),
      .out_val     (p_val[0]),
      .out_chroma  (p_chroma[0]),
      .out_sat_rem (p_sat_rem[0]),
      .out_sat_nq  (p_sat_nq[0]),
      .out_hue_rem (p_hue_rem[0]),
      .out_hue_nq  (p_hue_nq[0])
   );

   for (genvar k = 0; k < STEPS; k++) begin : g_div
      rhc_div_stage #(.CB(CB), .S(STEPS)) u_stage (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (p_valid[k]),
         .in_ready    (p_ready[k]),
         .in_side     (p_side[k]),
         .in_val      (p_val[k]),
         .in_chroma   (p_chroma[k]),
         .in_sat_rem  (p_sat_rem[k]),
         .in_sat_nq   (p_sat_nq[k]),
         .in_hue_rem  (p_hue_rem[k]),
         .in_hue_nq   (p_hue_nq[k]),
         .out_valid   (p_valid[k+1]),
         .out_ready   (p_ready[k+1]),
         .out_side    (p_side[k+1]),
         .out_val     (p_val[k+1]),
         .out_chroma  (p_chroma[k+1]),
         .out_sat_rem (p_sat_rem[k+1]),
         .out_sat_nq  (p_sat_nq[k+1]),
         .out_hue_rem (p_hue_rem[k+1]),
         .out_hue_nq  (p_hue_nq[k+1])
      );
   end

   rhc_back #(.CB(CB), .HFB(HFB), .S(STEPS), .HW(HW)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (p_valid[STEPS]),
      .in_ready   (p_ready[STEPS]),
      .in_side    (p_side[STEPS]),
      .in_val     (p_val[STEPS]),
      .in_sat_nq  (p_sat_nq[STEPS]),
      .in_hue_nq  (p_hue_nq[STEPS]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .hue        (hue),
      .saturation (saturation),
      .brightness (brightness)
   );

   assign rsp_tdata = RSP_W'({brightness, saturation, hue});

endmodule

FILE: rtl/core/rhc_front.sv
module rhc_front import rhc_pkg::*; #(
   parameter int CB  = 8,
   parameter int HFB = 8,
   parameter int S   = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [CB-1:0] red,
   input  logic [CB-1:0] green,
   input  logic [CB-1:0] blue,
   output logic          out_valid,
   input  logic          out_ready,
   output side_type      out_side,
   output logic [CB-1:0] out_val,
   output logic [CB-1:0] out_chroma,
   output logic [CB-1:0] out_sat_rem,
   output logic [S-1:0]  out_sat_nq,
   output logic [CB-1:0] out_hue_rem,
   output logic [S-1:0]  out_hue_nq
);

   localparam int DW = CB + S;

   logic            r_ge_g, r_ge_b, g_ge_b;
   logic [CB-1:0]   hi, lo, mag, chroma;
   logic signed [CB:0] diff;
   logic [DW-1:0]   sat_div, hue_div;

   logic            valid_ff;
   side_type        side_in, side_ff;
   logic [CB-1:0]   val_ff, chroma_ff, sat_rem_ff, hue_rem_ff;
   logic [S-1:0]    sat_nq_ff, hue_nq_ff;

   always_comb begin
      r_ge_g = red >= green;
      r_ge_b = red >= blue;
      g_ge_b = green >= blue;

      if (r_ge_g && r_ge_b) begin
         side_in.sector = SECTOR_RED;
      end else if (g_ge_b) begin
         side_in.sector = SECTOR_GREEN;
      end else begin
         side_in.sector = SECTOR_BLUE;
      end

      case (side_in.sector)
         SECTOR_GREEN: begin
            hi   = green;
            diff = $signed({1'b0, blue}) - $signed({1'b0, red});
         end
         SECTOR_BLUE: begin
            hi   = blue;
            diff = $signed({1'b0, red}) - $signed({1'b0, green});
         end
         default: begin
            hi   = red;
            diff = $signed({1'b0, green}) - $signed({1'b0, blue});
         end
      endcase

      lo = r_ge_g ? (g_ge_b ? blue : green) : (r_ge_b ? blue : red);

      chroma       = hi - lo;
      side_in.neg  = diff[CB];
      side_in.gray = (chroma == '0);
      mag          = side_in.neg ? CB'(-diff) : CB'(diff);

      sat_div = (DW'(chroma) << CB) - DW'(chroma);
      hue_div = DW'(mag) << HFB;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         side_ff    <= side_in;
         val_ff     <= hi;
         chroma_ff  <= chroma;
         sat_rem_ff <= sat_div[DW-1:S];
         sat_nq_ff  <= sat_div[S-1:0];
         hue_rem_ff <= hue_div[DW-1:S];
         hue_nq_ff  <= hue_div[S-1:0];
      end
   end

   assign out_valid   = valid_ff;
   assign out_side    = side_ff;
   assign out_val     = val_ff;
   assign out_chroma  = chroma_ff;
   assign out_sat_rem = sat_rem_ff;
   assign out_sat_nq  = sat_nq_ff;
   assign out_hue_rem = hue_rem_ff;
   assign out_hue_nq  = hue_nq_ff;

endmodule

FILE: rtl/core/rhc_div_stage.sv
module rhc_div_stage import rhc_pkg::*; #(
   parameter int CB = 8,
   parameter int S  = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  side_type      in_side,
   input  logic [CB-1:0] in_val,
   input  logic [CB-1:0] in_chroma,
   input  logic [CB-1:0] in_sat_rem,
   input  logic [S-1:0]  in_sat_nq,
   input  logic [CB-1:0] in_hue_rem,
   input  logic [S-1:0]  in_hue_nq,
   output logic          out_valid,
   input  logic          out_ready,
   output side_type      out_side,
   output logic [CB-1:0] out_val,
   output logic [CB-1:0] out_chroma,
   output logic [CB-1:0] out_sat_rem,
   output logic [S-1:0]  out_sat_nq,
   output logic [CB-1:0] out_hue_rem,
   output logic [S-1:0]  out_hue_nq
);

   // one restoring step per division: quotient bit shifts in at the low end
   logic [CB:0]   sat_t, hue_t, sat_d, hue_d;
   logic          sat_ge, hue_ge;
   logic [CB-1:0] sat_rem_in, hue_rem_in;
   logic [S-1:0]  sat_nq_in, hue_nq_in;

   logic          valid_ff;
   side_type      side_ff;
   logic [CB-1:0] val_ff, chroma_ff, sat_rem_ff, hue_rem_ff;
   logic [S-1:0]  sat_nq_ff, hue_nq_ff;

   always_comb begin
      sat_t      = {in_sat_rem, in_sat_nq[S-1]};
      sat_d      = sat_t - {1'b0, in_val};
      sat_ge     = sat_t >= {1'b0, in_val};
      sat_rem_in = sat_ge ? sat_d[CB-1:0] : sat_t[CB-1:0];
      sat_nq_in  = {in_sat_nq[S-2:0], sat_ge};

      hue_t      = {in_hue_rem, in_hue_nq[S-1]};
      hue_d      = hue_t - {1'b0, in_chroma};
      hue_ge     = hue_t >= {1'b0, in_chroma};
      hue_rem_in = hue_ge ? hue_d[CB-1:0] : hue_t[CB-1:0];
      hue_nq_in  = {in_hue_nq[S-2:0], hue_ge};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         side_ff    <= in_side;
         val_ff     <= in_val;
         chroma_ff  <= in_chroma;
         sat_rem_ff <= sat_rem_in;
         sat_nq_ff  <= sat_nq_in;
         hue_rem_ff <= hue_rem_in;
         hue_nq_ff  <= hue_nq_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_side    = side_ff;
   assign out_val     = val_ff;
   assign out_chroma  = chroma_ff;
   assign out_sat_rem = sat_rem_ff;
   assign out_sat_nq  = sat_nq_ff;
   assign out_hue_rem = hue_rem_ff;
   assign out_hue_nq  = hue_nq_ff;

endmodule

FILE: rtl/core/rhc_back.sv
module rhc_back import rhc_pkg::*; #(
   parameter int CB  = 8,
   parameter int HFB = 8,
   parameter int S   = 9,
   parameter int HW  = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  side_type      in_side,
   input  logic [CB-1:0] in_val,
   input  logic [S-1:0]  in_sat_nq,
   input  logic [S-1:0]  in_hue_nq,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [HW-1:0] hue,
   output logic [CB-1:0] saturation,
   output logic [CB-1:0] brightness
);

   localparam logic [HW:0] CIRCLE = (HW+1)'(6) << HFB;

   logic [HW:0]   base, q_ext, h_sum, h_wrap;
   logic [HW-1:0] hue_in, hue_ff;
   logic [CB-1:0] sat_in, sat_ff, val_ff;
   logic          valid_ff;

   always_comb begin
      case (in_side.sector)
         SECTOR_GREEN: base = (HW+1)'(2) << HFB;
         SECTOR_BLUE:  base = (HW+1)'(4) << HFB;
         default:      base = '0;
      endcase
      q_ext  = (HW+1)'(in_hue_nq[HFB:0]);
      h_sum  = in_side.neg ? (base - q_ext) : (base + q_ext);
      h_wrap = h_sum[HW] ? (h_sum + CIRCLE) : h_sum;
      hue_in = in_side.gray ? '0 : h_wrap[HW-1:0];
      sat_in = in_side.gray ? '0 : in_sat_nq[CB-1:0];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         val_ff <= in_val;
      end
   end

   assign out_valid  = valid_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign brightness = val_ff;

endmodule
